/* src/rdc_pkg.sv */
package rdc_pkg;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // End-of-record status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SUM   = 2'd1;
  localparam logic [1:0] ST_LEN_TRUNC = 2'd2;
  localparam logic [1:0] ST_BODY_TRUNC = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_FILL = 1'd1;
  localparam int unsigned CFG_DATA_W = 16;

  // Parse phases
  localparam logic [2:0] PH_LEN_LO = 3'd0;
  localparam logic [2:0] PH_LEN_HI = 3'd1;
  localparam logic [2:0] PH_BODY   = 3'd2;
  localparam logic [2:0] PH_CK_A   = 3'd3;
  localparam logic [2:0] PH_CK_B   = 3'd4;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       stream_end;
  } in_word_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic [15:0] pad_count;
    logic        last;
  } out_word_t;

endpackage

/* src/record_deframe_check.sv */
// An accepted input word that owes a result word has it registered onto out_* in the next cycle.
// Throughput: one input word per cycle; in_ready drops only while a result
// word is held in the output register and out_ready is low.
// Reset (rst_n, synchronous, active low): parser back to expecting the length
// low byte, sums and counters cleared, output register empty, registers zero.
module record_deframe_check
  import rdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,

  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [15:0] data_size_r;
  logic        tail_fill_r;

  // Record parse state
  logic [2:0]  phase_r,     phase_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] wanted_left_r, wanted_left_nxt;
  logic [7:0]  sum_a_r,     sum_a_nxt;
  logic [7:0]  sum_b_r,     sum_b_nxt;
  logic [7:0]  check_a_r,   check_a_nxt;

  // Output register: parts the input side from a stalled consumer
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_data_r,  out_data_nxt;

  logic        in_acc;
  logic [7:0]  add_a;      // sum_a after taking in the current byte
  logic [2:0]  phase_eff;  // unused codes fold onto length low byte
  logic        res_vld;
  out_word_t   res;

  // Accept a new word whenever the output register is free or being drained.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign add_a     = sum_a_r + in_data.byte_value;
  assign phase_eff = (phase_r > PH_CK_B) ? PH_LEN_LO : phase_r;

  // Per-word parse step: at most one result word.
  always_comb begin
    phase_nxt       = phase_r;
    bytes_left_nxt  = bytes_left_r;
    wanted_left_nxt = wanted_left_r;
    sum_a_nxt       = sum_a_r;
    sum_b_nxt       = sum_b_r;
    check_a_nxt     = check_a_r;
    res_vld         = 1'b0;
    res             = '0;

    if (in_data.stream_end) begin
      // Stream ran dry: close the record with a truncation status.
      res_vld       = 1'b1;
      res.out_kind  = KIND_END;
      res.last      = 1'b1;
      res.status    = (phase_eff == PH_LEN_LO || phase_eff == PH_LEN_HI) ?
                      ST_LEN_TRUNC : ST_BODY_TRUNC;
      phase_nxt       = PH_LEN_LO;
      bytes_left_nxt  = '0;
      wanted_left_nxt = '0;
      sum_a_nxt       = '0;
      sum_b_nxt       = '0;
      check_a_nxt     = '0;
    end else begin
      unique case (phase_eff)
        PH_LEN_HI: begin
          sum_a_nxt      = add_a;
          sum_b_nxt      = sum_b_r + add_a;
          bytes_left_nxt = {in_data.byte_value, bytes_left_r[7:0]};
          phase_nxt      = ({in_data.byte_value, bytes_left_r[7:0]} != 16'd0) ?
                           PH_BODY : PH_CK_A;
        end
        PH_BODY: begin
          sum_a_nxt      = add_a;
          sum_b_nxt      = sum_b_r + add_a;
          bytes_left_nxt = bytes_left_r - 16'd1;
          if (bytes_left_r == 16'd1) begin
            phase_nxt = PH_CK_A;
          end
          // Deliver only the bytes the caller asked for; drop the rest.
          if (wanted_left_r != 16'd0) begin
            wanted_left_nxt = wanted_left_r - 16'd1;
            res_vld         = 1'b1;
            res.out_kind    = KIND_DATA;
            res.data_byte   = in_data.byte_value;
          end
        end
        PH_CK_A: begin
          check_a_nxt = in_data.byte_value;
          phase_nxt   = PH_CK_B;
        end
        PH_CK_B: begin
          res_vld       = 1'b1;
          res.out_kind  = KIND_END;
          res.last      = 1'b1;
          res.status    = (check_a_r == sum_a_r && in_data.byte_value == sum_b_r) ?
                          ST_OK : ST_BAD_SUM;
          res.pad_count = tail_fill_r ? wanted_left_r : 16'd0;
          phase_nxt       = PH_LEN_LO;
          bytes_left_nxt  = '0;
          wanted_left_nxt = '0;
          sum_a_nxt       = '0;
          sum_b_nxt       = '0;
          check_a_nxt     = '0;
        end
        default: begin
          // Length low byte: start a fresh record, latch the wanted size.
          sum_a_nxt       = in_data.byte_value;
          sum_b_nxt       = in_data.byte_value;
          bytes_left_nxt  = {8'd0, in_data.byte_value};
          wanted_left_nxt = data_size_r;
          check_a_nxt     = '0;
          phase_nxt       = PH_LEN_HI;
        end
      endcase
    end
  end

  // Output register: load on accept, else clear once drained.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_acc) begin
      out_valid_nxt = res_vld;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_size_r   <= '0;
      tail_fill_r   <= 1'b0;
      phase_r       <= PH_LEN_LO;
      bytes_left_r  <= '0;
      wanted_left_r <= '0;
      sum_a_r       <= '0;
      sum_b_r       <= '0;
      check_a_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DATA_SIZE: data_size_r <= cfg_wdata;
          REG_TAIL_FILL: tail_fill_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_acc) begin
        phase_r       <= phase_nxt;
        bytes_left_r  <= bytes_left_nxt;
        wanted_left_r <= wanted_left_nxt;
        sum_a_r       <= sum_a_nxt;
        sum_b_r       <= sum_b_nxt;
        check_a_r     <= check_a_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register: no reset needed.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Between records no counter or sum may carry over.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LEN_LO |-> (wanted_left_r == 16'd0 && bytes_left_r == 16'd0 &&
                             sum_a_r == 8'd0 && sum_b_r == 8'd0))
    else $error("state carried over into a new record");

  // A truncated stream always closes the record.
  a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.stream_end |=> phase_r == PH_LEN_LO && out_valid_r &&
                                      out_data_r.last)
    else $error("stream end did not close the record");

  // Data words carry no status or padding; end words carry last.
  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.out_kind == KIND_DATA) ?
      (out_data_r.status == ST_OK && out_data_r.pad_count == 16'd0 && !out_data_r.last) :
      (out_data_r.last && out_data_r.data_byte == 8'd0))
    else $error("result word fields inconsistent with kind");

  // Parse state moves only on an accepted word.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(phase_r) && $stable(wanted_left_r))
    else $error("parse state moved without an input word");

endmodule

/* tb/record_frame_monitor.sv */
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts the result words of
// every accepted input word and compares them in order with what comes out.
module record_frame_monitor
  import rdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_word_t              in_data,

  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_word_t             out_data,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,

  output int                    mismatches,
  output int                    pending
);

  localparam int PRINT_CAP = 40;

  logic [15:0] wanted_size;
  logic        fill_on;

  logic [2:0]  phase;
  logic [16:0] body_left;
  logic [15:0] deliver_left;
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic [7:0]  got_check_a;

  out_word_t   due_words[$];

  function automatic void restart_record();
    phase        = PH_LEN_LO;
    body_left    = '0;
    deliver_left = '0;
    sum_a        = '0;
    sum_b        = '0;
    got_check_a  = '0;
  endfunction

  function automatic void fold(input logic [7:0] v);
    sum_a = sum_a + v;
    sum_b = sum_b + sum_a;
  endfunction

  // Advance the record parser by one word; queue the result word it owes.
  function automatic void predict_word(input in_word_t w);
    out_word_t   r;
    logic [2:0]  ph;
    logic [7:0]  v;
    r  = '0;
    v  = w.byte_value;
    ph = phase;
    if (ph > PH_CK_B) ph = PH_LEN_LO;

    if (w.stream_end) begin
      r.out_kind = KIND_END;
      r.last     = 1'b1;
      r.status   = (ph == PH_LEN_LO || ph == PH_LEN_HI) ? ST_LEN_TRUNC : ST_BODY_TRUNC;
      due_words.push_back(r);
      restart_record();
    end else begin
      case (ph)
        PH_LEN_HI: begin
          fold(v);
          body_left = {1'b0, v, body_left[7:0]};
          phase     = (body_left != '0) ? PH_BODY : PH_CK_A;
        end
        PH_BODY: begin
          fold(v);
          body_left = body_left - 17'd1;
          if (body_left == '0) phase = PH_CK_A;
          if (deliver_left != '0) begin
            deliver_left = deliver_left - 16'd1;
            r.out_kind   = KIND_DATA;
            r.data_byte  = v;
            due_words.push_back(r);
          end
        end
        PH_CK_A: begin
          got_check_a = v;
          phase       = PH_CK_B;
        end
        PH_CK_B: begin
          r.out_kind  = KIND_END;
          r.last      = 1'b1;
          r.status    = (got_check_a == sum_a && v == sum_b) ? ST_OK : ST_BAD_SUM;
          r.pad_count = fill_on ? deliver_left : 16'd0;
          due_words.push_back(r);
          restart_record();
        end
        default: begin
          restart_record();
          fold(v);
          body_left    = {9'd0, v};
          deliver_left = wanted_size;
          phase        = PH_LEN_HI;
        end
      endcase
    end
  endfunction

  function automatic bit field_ok(input string name, input logic [15:0] want,
                                  input logic [15:0] got);
    if (want !== got) begin
      if (mismatches < PRINT_CAP)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    bit        ok;
    if (!rst_n) begin
      wanted_size = '0;
      fill_on     = 1'b0;
      restart_record();
      due_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DATA_SIZE: wanted_size = cfg_wdata;
          REG_TAIL_FILL: fill_on = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_word(in_data);
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          if (mismatches < PRINT_CAP)
            $display("%0t: no word expected, got %h", $time, out_data);
          mismatches++;
        end else begin
          want = due_words.pop_front();
          ok = field_ok("out_kind", 16'(want.out_kind), 16'(out_data.out_kind));
          ok &= field_ok("data_byte", 16'(want.data_byte), 16'(out_data.data_byte));
          ok &= field_ok("status", 16'(want.status), 16'(out_data.status));
          ok &= field_ok("pad_count", want.pad_count, out_data.pad_count);
          ok &= field_ok("last", 16'(want.last), 16'(out_data.last));
          if (!ok) mismatches++;
        end
      end
    end
    pending = due_words.size();
  end

endmodule

/* tb/record_deframe_check_test.sv */
`timescale 1ns / 1ps

module record_deframe_check_test;
  import rdc_pkg::*;

  // Cycles to let pass after the last expected word before touching the
  // registers or ending: the block answers in the cycle after it takes a word.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Length of the deliberate receiver hold-off that fills the block up.
  localparam int unsigned LONG_HOLD = 120;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_word_t              in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_DATA_SIZE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                  in_ready;
  logic                  out_valid;
  out_word_t             out_data;

  int                    mismatches;
  int                    pending;

  // Words still to be offered in the current stretch, and a record tail
  // parked across a register change.
  in_word_t              stream_q[$];
  in_word_t              carry_q[$];

  // Set to run both sides flat out; bumped by the stimulus to ask the
  // receiver for one long hold-off.
  bit                    quiet = 1'b0;
  int unsigned           stall_requests = 0;

  always #5 clk = ~clk;

  record_deframe_check DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  record_frame_monitor monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Idle length for either side: mostly none or a short gap, now and then
  // a long gap; nothing at all while running quiet.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    in_word_t w;
    w.byte_value = b;
    w.stream_end = 1'b0;
    stream_q.push_back(w);
  endfunction

  // End of stream; the byte lane carries junk, which the block must ignore.
  function automatic void push_end();
    in_word_t w;
    w.byte_value = 8'($urandom_range(0, 255));
    w.stream_end = 1'b1;
    stream_q.push_back(w);
  endfunction

  // Queue one record: length low, length high, payload, check A, check B.
  // Spoil flips one bit of one check byte. A non-negative cut keeps only
  // that many bytes of the frame and then ends the stream. Extremes makes
  // the payload alternate between all-zero and all-one bytes.
  function automatic void add_frame(input int unsigned len, input bit spoil,
                                    input int cut, input bit extremes);
    logic [7:0] frame[$];
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] v;
    a = '0;
    b = '0;
    for (int unsigned i = 0; i < len + 2; i++) begin
      if (i == 0) v = len[7:0];
      else if (i == 1) v = len[15:8];
      else if (extremes) v = {8{i[0]}};
      else v = 8'($urandom_range(0, 255));
      a = a + v;
      b = b + a;
      frame.push_back(v);
    end
    if (spoil) begin
      if ($urandom_range(0, 1)) a = a ^ (8'd1 << $urandom_range(0, 7));
      else b = b ^ (8'd1 << $urandom_range(0, 7));
    end
    frame.push_back(a);
    frame.push_back(b);
    if (cut >= 0) begin
      while (frame.size() > cut) void'(frame.pop_back());
    end
    foreach (frame[k]) push_byte(frame[k]);
    if (cut >= 0) push_end();
  endfunction

  // Wait until every expected word has come out, then let the block settle
  // in case the last word taken owed nothing.
  task automatic settle();
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Program both registers with the block idle, then offer every queued
  // word with random gaps. Squeeze asks the receiver for a long hold-off
  // while the words keep coming.
  task automatic run_phase(input logic [15:0] size, input bit fill, input bit squeeze);
    in_word_t    w;
    int unsigned gap;
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DATA_SIZE;
    cfg_wdata <= size;
    @(negedge clk);
    cfg_index <= REG_TAIL_FILL;
    cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, fill};
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (squeeze) stall_requests++;
    while (stream_q.size() != 0) begin
      w   = stream_q.pop_front();
      gap = idle_len();
      @(negedge clk);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      // Hold valid and the word steady until the block takes it.
      in_valid <= 1'b1;
      in_data  <= w;
      do @(posedge clk); while (!in_ready);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Receiver: random stalls of random length, plus one long hold-off on
  // request so that the output register fills and in_ready drops.
  initial begin : result_sink
    int unsigned hold;
    int unsigned stalls_seen;
    stalls_seen = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_requests != stalls_seen) begin
        stalls_seen = stall_requests;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        hold = idle_len();
        if (hold != 0) begin
          out_ready <= 1'b0;
          repeat (hold) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [15:0] size;
    int unsigned len;
    int unsigned r;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed records, three bytes wanted and padding reported:
    // end of stream before any byte, end of stream inside the length,
    // an empty payload, a spoilt checksum over all-zero and all-one bytes,
    // a cut inside the payload and a cut between the two check bytes.
    push_end();
    push_byte(8'hFF);
    push_end();
    add_frame(0, 1'b0, -1, 1'b0);
    add_frame(2, 1'b1, -1, 1'b1);
    add_frame(5, 1'b0, 5, 1'b0);
    add_frame(1, 1'b0, 4, 1'b0);
    run_phase(16'd3, 1'b1, 1'b0);

    // Largest wanted size: an empty record owes the full padding count.
    // Park the second half of the next record so that the registers change
    // in the middle of it; the latched wanted size must still hold.
    add_frame(0, 1'b0, -1, 1'b0);
    add_frame(4, 1'b0, -1, 1'b0);
    repeat (4) carry_q.push_front(stream_q.pop_back());
    run_phase(16'hFFFF, 1'b1, 1'b0);
    stream_q = carry_q;
    carry_q.delete();
    add_frame(3, 1'b0, -1, 1'b0);
    run_phase(16'd0, 1'b0, 1'b0);

    // Random phases: mostly well-formed records with random content, some
    // with a spoilt checksum, some cut short, plus stray ends and junk.
    for (int p = 0; p < 8; p++) begin
      while (stream_q.size() < 70) begin
        r   = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        if (r < 65) begin
          add_frame(len, 1'b0, -1, 1'b0);
        end else if (r < 78) begin
          add_frame(len, 1'b1, -1, 1'b0);
        end else if (r < 90) begin
          add_frame(len, 1'b0, $urandom_range(0, len + 3), 1'b0);
        end else if (r < 95) begin
          push_end();
        end else begin
          // Junk bytes; the end word brings the parser back in step.
          repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
          push_end();
        end
      end
      case ($urandom_range(0, 4))
        0:       size = 16'd0;
        1:       size = 16'($urandom_range(1, 8));
        2:       size = 16'($urandom_range(9, 48));
        3:       size = 16'hFFFF;
        default: size = 16'($urandom_range(0, 65535));
      endcase
      // Phase two delivers every payload byte and carries the long
      // hold-off; phase five runs without gaps on either side.
      if (p == 2) size = 16'hFFFF;
      quiet = (p == 5);
      run_phase(size, 1'($urandom_range(0, 1)), p == 2);
    end

    // Longest lengths, both cut short in the payload: the top two lengths
    // must be taken in without wrapping the byte count.
    quiet = 1'b1;
    add_frame(65534, 1'b0, 20, 1'b0);
    add_frame(65535, 1'b0, 14, 1'b0);
    run_phase(16'hFFFF, 1'b1, 1'b0);
    quiet = 1'b0;

    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Stop a hung run well past the slowest correct one.
  initial begin : watchdog
    #200_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
src/rdc_pkg.sv
src/record_deframe_check.sv
tb/record_frame_monitor.sv
tb/record_deframe_check_test.sv
